// ===== hdl/crs_pkg.sv =====
// Package: shared constants and types for the Catmull-Rom spline evaluator.
`default_nettype none
package crs_pkg;
  localparam int unsigned MaxPointsDef = 64;
  localparam int unsigned CoordBitsDef = 32;
  localparam int unsigned ParamFracDef = 16;
  localparam int unsigned CntBits      = 7;

  typedef enum logic [0:0] {
    CfgPointCount = 1'b0,
    CfgLoopMode   = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    ActLoad = 1'b0,
    ActEval = 1'b1
  } action_e;
endpackage
`default_nettype wire

// ===== hdl/catmull_rom_spline_eval_unit.sv =====
// Catmull-Rom spline evaluator: one load or evaluate word accepted per cycle while the output is not
// back-pressured. Three coordinate lanes run in parallel, fed by the point table (two copies with
// two read ports each), and a merge stage saturates. Table writes go through a registered address
// and data stage after the load word so that evaluations already in flight read the older contents.
// Back-pressure stalls the whole pipeline.
`default_nettype none
module catmull_rom_spline_eval_unit import crs_pkg::*; #(
  parameter int unsigned MaxPoints = MaxPointsDef,
  parameter int unsigned CoordBits = CoordBitsDef,
  parameter int unsigned ParamFrac = ParamFracDef
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        cfg_we_i,
  input  wire [0:0]                  cfg_idx_i,
  input  wire [CntBits-1:0]          cfg_data_i,
  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  wire                        action_i,
  input  wire [5:0]                  point_index_i,
  input  wire signed [CoordBits-1:0] in_x_i,
  input  wire signed [CoordBits-1:0] in_y_i,
  input  wire signed [CoordBits-1:0] in_z_i,
  input  wire [ParamFrac:0]          curve_param_i,
  output logic                       out_valid_o,
  input  wire                        out_ready_i,
  output logic signed [CoordBits-1:0] pos_x_o,
  output logic signed [CoordBits-1:0] pos_y_o,
  output logic signed [CoordBits-1:0] pos_z_o,
  output logic signed [CoordBits-1:0] slope_x_o,
  output logic signed [CoordBits-1:0] slope_y_o,
  output logic signed [CoordBits-1:0] slope_z_o
);
  localparam int unsigned IdxBits = $clog2(MaxPoints);
  localparam int unsigned One     = 1 << ParamFrac;
  localparam int unsigned SegBits = CntBits + 1;
  localparam int unsigned WBits   = ParamFrac + SegBits + 6;
  localparam int unsigned SBits   = CoordBits + WBits + 2;
  localparam int unsigned Stages  = 6;

  logic [CntBits-1:0] cnt_q;
  logic               loop_q;
  logic [3*CoordBits-1:0] tbl_a [MaxPoints];
  logic [3*CoordBits-1:0] tbl_b [MaxPoints];
  logic                   wv_q;
  logic [IdxBits-1:0]     wa_q;
  logic [3*CoordBits-1:0] wd_q;

  logic [Stages-1:0] v_q;
  logic adv;
  assign out_valid_o = v_q[Stages-1];
  assign adv = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= CntBits'(4);
      loop_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgPointCount: cnt_q  <= cfg_data_i;
        CfgLoopMode:   loop_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  wire acc = in_valid_i && in_ready_o;

  // table write one step behind the load word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) wv_q <= 1'b0;
    else if (adv) begin
      wv_q <= acc && action_e'(action_i) == ActLoad && 32'(point_index_i) < MaxPoints;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      wa_q <= IdxBits'(point_index_i);
      wd_q <= {in_z_i, in_y_i, in_x_i};
    end
    if (adv && wv_q) begin
      tbl_a[wa_q] <= wd_q;
      tbl_b[wa_q] <= wd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (adv) v_q <= {v_q[Stages-2:0], acc && action_e'(action_i) == ActEval};
  end

  // stage 1: segment count, clamped parameter, scaled
  logic [SegBits-1:0] n_c, segs_c;
  logic [ParamFrac:0] u_c;
  logic [SegBits-1:0] n1_q, segs1_q;
  logic [ParamFrac+SegBits:0] sc1_q;
  always_comb begin
    n_c = SegBits'(cnt_q);
    if (n_c < SegBits'(2)) n_c = SegBits'(2);
    if (32'(n_c) > MaxPoints) n_c = SegBits'(MaxPoints);
    segs_c = loop_q ? n_c : n_c - SegBits'(1);
    u_c = (32'(curve_param_i) > One) ? (ParamFrac+1)'(One) : curve_param_i;
  end
  always_ff @(posedge clk_i) if (adv) begin
    n1_q <= n_c; segs1_q <= segs_c;
    sc1_q <= (ParamFrac+SegBits+1)'(u_c * segs_c);
  end

  // stage 2: segment, t, indices
  logic [SegBits-1:0] seg_c;
  logic [SegBits-1:0] segs2_q;
  logic [ParamFrac:0] t2_q;
  logic [IdxBits-1:0] ix2_q [4];
  logic [SegBits:0] a_c, b_c, c_c;
  always_comb begin
    seg_c = SegBits'(sc1_q >> ParamFrac);
    if (seg_c >= segs1_q) seg_c = segs1_q - SegBits'(1);
    a_c = (seg_c == '0) ? (SegBits+1)'(n1_q - SegBits'(1)) : (SegBits+1)'(seg_c - SegBits'(1));
    b_c = (SegBits+1)'(seg_c) + (SegBits+1)'(1);
    if (b_c >= (SegBits+1)'(n1_q)) b_c = b_c - (SegBits+1)'(n1_q);
    c_c = (SegBits+1)'(seg_c) + (SegBits+1)'(2);
    if (c_c >= (SegBits+1)'(n1_q)) c_c = c_c - (SegBits+1)'(n1_q);
    if (c_c >= (SegBits+1)'(n1_q)) c_c = c_c - (SegBits+1)'(n1_q);
  end
  always_ff @(posedge clk_i) if (adv) begin
    segs2_q <= segs1_q;
    t2_q <= (ParamFrac+1)'(sc1_q - ((ParamFrac+SegBits+1)'(seg_c) << ParamFrac));
    ix2_q[0] <= IdxBits'(a_c); ix2_q[1] <= IdxBits'(seg_c);
    ix2_q[2] <= IdxBits'(b_c); ix2_q[3] <= IdxBits'(c_c);
  end

  // stage 3: t^2, fetch points
  logic [ParamFrac+1:0] sq3_q;
  logic [ParamFrac:0] t3_q;
  logic [SegBits-1:0] segs3_q;
  logic [3*CoordBits-1:0] e3_q [4];
  logic [2*ParamFrac+1:0] sq_c;
  assign sq_c = t2_q * t2_q;
  always_ff @(posedge clk_i) if (adv) begin
    sq3_q <= (ParamFrac+2)'(sq_c >> ParamFrac);
    t3_q <= t2_q; segs3_q <= segs2_q;
    e3_q[0] <= tbl_a[ix2_q[0]];
    e3_q[1] <= tbl_a[ix2_q[1]];
    e3_q[2] <= tbl_b[ix2_q[2]];
    e3_q[3] <= tbl_b[ix2_q[3]];
  end

  // stage 4: t^3, weights
  logic [2*ParamFrac+2:0] cu_c;
  logic signed [WBits-1:0] t_s, s2_s, s3_s, sg_s, w4_q [4], g4_q [4];
  logic signed [WBits-1:0] gp_c [4];
  logic signed [CoordBits-1:0] px4_q [4], py4_q [4], pz4_q [4];
  always_comb begin
    cu_c = sq3_q * t3_q;
    t_s  = WBits'(t3_q);
    s2_s = WBits'(sq3_q);
    s3_s = WBits'(cu_c >> ParamFrac);
    sg_s = WBits'(segs3_q);
    gp_c[0] = WBits'(-3*s2_s + 4*t_s - WBits'(One));
    gp_c[1] = WBits'(9*s2_s - 10*t_s);
    gp_c[2] = WBits'(-9*s2_s + 8*t_s + WBits'(One));
    gp_c[3] = WBits'(3*s2_s - 2*t_s);
  end
  always_ff @(posedge clk_i) if (adv) begin
    w4_q[0] <= WBits'(-s3_s + 2*s2_s - t_s);
    w4_q[1] <= WBits'(3*s3_s - 5*s2_s + WBits'(2*One));
    w4_q[2] <= WBits'(-3*s3_s + 4*s2_s + t_s);
    w4_q[3] <= WBits'(s3_s - s2_s);
    for (int i = 0; i < 4; i++) begin
      g4_q[i] <= WBits'(gp_c[i] * sg_s);
      px4_q[i] <= e3_q[i][CoordBits-1:0];
      py4_q[i] <= e3_q[i][2*CoordBits-1:CoordBits];
      pz4_q[i] <= e3_q[i][3*CoordBits-1:2*CoordBits];
    end
  end

  // stages 5-6: lanes
  logic signed [SBits-1:0] ps [3], ss [3];
  crs_lane #(.CoordBits(CoordBits), .WBits(WBits)) u_lx (
    .clk_i, .en_i(adv), .p_i(px4_q), .w_i(w4_q), .g_i(g4_q), .pos_o(ps[0]), .slope_o(ss[0]));
  crs_lane #(.CoordBits(CoordBits), .WBits(WBits)) u_ly (
    .clk_i, .en_i(adv), .p_i(py4_q), .w_i(w4_q), .g_i(g4_q), .pos_o(ps[1]), .slope_o(ss[1]));
  crs_lane #(.CoordBits(CoordBits), .WBits(WBits)) u_lz (
    .clk_i, .en_i(adv), .p_i(pz4_q), .w_i(w4_q), .g_i(g4_q), .pos_o(ps[2]), .slope_o(ss[2]));

  crs_sat #(.InBits(SBits), .Shift(ParamFrac+1), .CoordBits(CoordBits)) u_spx (
    .v_i(ps[0]), .v_o(pos_x_o));
  crs_sat #(.InBits(SBits), .Shift(ParamFrac+1), .CoordBits(CoordBits)) u_spy (
    .v_i(ps[1]), .v_o(pos_y_o));
  crs_sat #(.InBits(SBits), .Shift(ParamFrac+1), .CoordBits(CoordBits)) u_spz (
    .v_i(ps[2]), .v_o(pos_z_o));
  crs_sat #(.InBits(SBits), .Shift(ParamFrac+1), .CoordBits(CoordBits)) u_ssx (
    .v_i(ss[0]), .v_o(slope_x_o));
  crs_sat #(.InBits(SBits), .Shift(ParamFrac+1), .CoordBits(CoordBits)) u_ssy (
    .v_i(ss[1]), .v_o(slope_y_o));
  crs_sat #(.InBits(SBits), .Shift(ParamFrac+1), .CoordBits(CoordBits)) u_ssz (
    .v_i(ss[2]), .v_o(slope_z_o));
endmodule
`default_nettype wire

// ===== hdl/crs_lane.sv =====
// One coordinate lane: four weighted products for position and slope, summed.
`default_nettype none
module crs_lane import crs_pkg::*; #(
  parameter int unsigned CoordBits = CoordBitsDef,
  parameter int unsigned WBits     = 24
) (
  input  wire                          clk_i,
  input  wire                          en_i,
  input  wire signed [CoordBits-1:0]   p_i [4],
  input  wire signed [WBits-1:0]       w_i [4],
  input  wire signed [WBits-1:0]       g_i [4],
  output logic signed [CoordBits+WBits+1:0] pos_o,
  output logic signed [CoordBits+WBits+1:0] slope_o
);
  localparam int unsigned PBits = CoordBits + WBits;
  logic signed [PBits-1:0] pm_q [4];
  logic signed [PBits-1:0] gm_q [4];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) begin
        pm_q[i] <= PBits'(w_i[i] * p_i[i]);
        gm_q[i] <= PBits'(g_i[i] * p_i[i]);
      end
      pos_o   <= (PBits+2)'(pm_q[0]) + (PBits+2)'(pm_q[1])
               + (PBits+2)'(pm_q[2]) + (PBits+2)'(pm_q[3]);
      slope_o <= (PBits+2)'(gm_q[0]) + (PBits+2)'(gm_q[1])
               + (PBits+2)'(gm_q[2]) + (PBits+2)'(gm_q[3]);
    end
  end
endmodule
`default_nettype wire

// ===== hdl/crs_sat.sv =====
// Merge stage: shift the lane sums down and saturate to the coordinate range.
`default_nettype none
module crs_sat import crs_pkg::*; #(
  parameter int unsigned InBits    = 58,
  parameter int unsigned Shift     = 17,
  parameter int unsigned CoordBits = CoordBitsDef
) (
  input  wire signed [InBits-1:0]    v_i,
  output logic signed [CoordBits-1:0] v_o
);
  logic signed [InBits-1:0] sh;
  localparam logic signed [InBits-1:0] Hi = InBits'({1'b0, {(CoordBits-1){1'b1}}});
  localparam logic signed [InBits-1:0] Lo = -Hi - InBits'(1);
  always_comb begin
    sh = v_i >>> Shift;
    if (sh > Hi) v_o = {1'b0, {(CoordBits-1){1'b1}}};
    else if (sh < Lo) v_o = {1'b1, {(CoordBits-1){1'b0}}};
    else v_o = sh[CoordBits-1:0];
  end
endmodule
`default_nettype wire
